@@ sv/vml_pkg.sv @@
// shared widths, latency and request sideband type for the vector magnitude limiter
// no dependencies
package vml_pkg;

   localparam int unsigned CW      = 16;
   localparam int unsigned LATENCY = 2 * CW + 4;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic [CW-1:0]        lim;
      logic                 sat;
   } side_type;

endpackage

@@ sv/vector_magnitude_limiter.sv @@
// top level of the vector magnitude limiter: squares, root, scale and divide pipeline
// depends on vml_pkg, vml_sqrt, vml_div
//
// Fully pipelined: a request is taken in every cycle (busy is always low) and its
// result appears on the rsp_ ports, marked by rsp_valid for one cycle, after passing
// the squares, sum, square root, scale, divider and output registers in that order.
// The square root and the divider each resolve one result bit per stage.
// Results cannot be held off by the receiver.
module vector_magnitude_limiter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [vml_pkg::CW-1:0] req_x_in,
   input  logic signed [vml_pkg::CW-1:0] req_y_in,
   input  logic [vml_pkg::CW-1:0]        req_limit,
   output logic                          rsp_valid,
   output logic signed [vml_pkg::CW-1:0] rsp_x_out,
   output logic signed [vml_pkg::CW-1:0] rsp_y_out,
   output logic                          rsp_saturated
);

   localparam int unsigned W = vml_pkg::CW;

   // stage 1: magnitudes and squares
   logic                    s1_valid_ff;
   logic [2*W-1:0]          s1_xsq_ff;
   logic [2*W-1:0]          s1_ysq_ff;
   vml_pkg::side_type       s1_side_ff;
   logic [W-1:0]            ax_in;
   logic [W-1:0]            ay_in;
   vml_pkg::side_type       side_in;

   // stage 2: sum of squares
   logic                    s2_valid_ff;
   logic [2*W-1:0]          s2_sum_ff;
   vml_pkg::side_type       s2_side_ff;

   // root
   logic                    rt_valid;
   logic [W-1:0]            rt_root;
   vml_pkg::side_type       rt_side;

   // scale stage
   logic                    s3_valid_ff;
   logic [2*W-1:0]          s3_px_ff;
   logic [2*W-1:0]          s3_py_ff;
   logic [W-1:0]            s3_den_ff;
   vml_pkg::side_type       s3_side_ff;
   logic [W-1:0]            rax;
   logic [W-1:0]            ray;
   vml_pkg::side_type       s3_side_in;

   // divide
   logic                    dv_valid;
   logic [W-1:0]            dv_qx;
   logic [W-1:0]            dv_qy;
   vml_pkg::side_type       dv_side;

   logic signed [W-1:0]     x_out_in;
   logic signed [W-1:0]     y_out_in;
   logic                    rsp_valid_ff;
   logic signed [W-1:0]     rsp_x_ff;
   logic signed [W-1:0]     rsp_y_ff;
   logic                    rsp_sat_ff;

   assign busy = 1'b0;

   assign ax_in = req_x_in[W-1] ? W'(-req_x_in) : W'(req_x_in);
   assign ay_in = req_y_in[W-1] ? W'(-req_y_in) : W'(req_y_in);
   always_comb begin
      side_in     = '0;
      side_in.x   = req_x_in;
      side_in.y   = req_y_in;
      side_in.lim = req_limit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
         s2_valid_ff <= s1_valid_ff;
      end
      s1_xsq_ff  <= ax_in * ax_in;
      s1_ysq_ff  <= ay_in * ay_in;
      s1_side_ff <= side_in;
      s2_sum_ff  <= s1_xsq_ff + s1_ysq_ff;
      s2_side_ff <= s1_side_ff;
   end

   vml_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_value  (s2_sum_ff),
      .in_side   (s2_side_ff),
      .out_valid (rt_valid),
      .out_root  (rt_root),
      .out_side  (rt_side)
   );

   assign rax = rt_side.x[W-1] ? W'(-rt_side.x) : W'(rt_side.x);
   assign ray = rt_side.y[W-1] ? W'(-rt_side.y) : W'(rt_side.y);
   always_comb begin
      s3_side_in     = rt_side;
      s3_side_in.sat = rt_root > rt_side.lim;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= rt_valid;
      end
      s3_px_ff   <= rax * rt_side.lim;
      s3_py_ff   <= ray * rt_side.lim;
      s3_den_ff  <= rt_root;
      s3_side_ff <= s3_side_in;
   end

   vml_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_num_a  (s3_px_ff),
      .in_num_b  (s3_py_ff),
      .in_den    (s3_den_ff),
      .in_side   (s3_side_ff),
      .out_valid (dv_valid),
      .out_quo_a (dv_qx),
      .out_quo_b (dv_qy),
      .out_side  (dv_side)
   );

   always_comb begin
      if (dv_side.sat) begin
         x_out_in = dv_side.x[W-1] ? W'(-dv_qx) : W'(dv_qx);
         y_out_in = dv_side.y[W-1] ? W'(-dv_qy) : W'(dv_qy);
      end else begin
         x_out_in = dv_side.x;
         y_out_in = dv_side.y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_valid;
      end
      rsp_x_ff   <= x_out_in;
      rsp_y_ff   <= y_out_in;
      rsp_sat_ff <= dv_side.sat;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_x_out     = rsp_x_ff;
   assign rsp_y_out     = rsp_y_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule

@@ sv/vml_sqrt.sv @@
// pipelined floor square root, one root bit per register stage
// depends on vml_pkg
module vml_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [2*vml_pkg::CW-1:0]      in_value,
   input  vml_pkg::side_type             in_side,
   output logic                          out_valid,
   output logic [vml_pkg::CW-1:0]        out_root,
   output vml_pkg::side_type             out_side
);

   logic                         valid_ff [vml_pkg::CW];
   logic [2*vml_pkg::CW-1:0]     num_ff   [vml_pkg::CW];
   logic [vml_pkg::CW+1:0]       rem_ff   [vml_pkg::CW];
   logic [vml_pkg::CW-1:0]       root_ff  [vml_pkg::CW];
   vml_pkg::side_type            side_ff  [vml_pkg::CW];

   for (genvar k = 0; k < vml_pkg::CW; k++) begin : g_stage
      logic                     src_valid;
      logic [2*vml_pkg::CW-1:0] src_num;
      logic [vml_pkg::CW+1:0]   src_rem;
      logic [vml_pkg::CW-1:0]   src_root;
      vml_pkg::side_type        src_side;
      logic [vml_pkg::CW+2:0]   rem_wide;
      logic [vml_pkg::CW+2:0]   trial;
      logic                     take;
      logic [vml_pkg::CW+1:0]   rem_in;
      logic [vml_pkg::CW-1:0]   root_in;

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_num   = in_value;
         assign src_rem   = '0;
         assign src_root  = '0;
         assign src_side  = in_side;
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src_num   = num_ff[k-1];
         assign src_rem   = rem_ff[k-1];
         assign src_root  = root_ff[k-1];
         assign src_side  = side_ff[k-1];
      end

      // bring down the next two bits and try root*4+1
      assign rem_wide = {src_rem[vml_pkg::CW:0], src_num[2*vml_pkg::CW-1 -: 2]};
      assign trial    = {1'b0, src_root, 2'b01};
      assign take     = rem_wide >= trial;
      always_comb begin
         if (take) begin
            rem_in = (vml_pkg::CW+2)'(rem_wide - trial);
         end else begin
            rem_in = rem_wide[vml_pkg::CW+1:0];
         end
      end
      assign root_in = {src_root[vml_pkg::CW-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= src_valid;
         end
         num_ff[k]  <= {src_num[2*vml_pkg::CW-3:0], 2'b00};
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         side_ff[k] <= src_side;
      end
   end

   assign out_valid = valid_ff[vml_pkg::CW-1];
   assign out_root  = root_ff[vml_pkg::CW-1];
   assign out_side  = side_ff[vml_pkg::CW-1];

endmodule

@@ sv/vml_div.sv @@
// pipelined two-lane restoring divider sharing one divisor, one quotient bit per stage
// depends on vml_pkg; quotient must fit CW bits
module vml_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [2*vml_pkg::CW-1:0]      in_num_a,
   input  logic [2*vml_pkg::CW-1:0]      in_num_b,
   input  logic [vml_pkg::CW-1:0]        in_den,
   input  vml_pkg::side_type             in_side,
   output logic                          out_valid,
   output logic [vml_pkg::CW-1:0]        out_quo_a,
   output logic [vml_pkg::CW-1:0]        out_quo_b,
   output vml_pkg::side_type             out_side
);

   logic                      valid_ff [vml_pkg::CW];
   logic [vml_pkg::CW-1:0]    den_ff   [vml_pkg::CW];
   logic [vml_pkg::CW-1:0]    rem_ff   [vml_pkg::CW][2];
   logic [vml_pkg::CW-1:0]    low_ff   [vml_pkg::CW][2];
   logic [vml_pkg::CW-1:0]    quo_ff   [vml_pkg::CW][2];
   vml_pkg::side_type         side_ff  [vml_pkg::CW];

   for (genvar k = 0; k < vml_pkg::CW; k++) begin : g_stage
      logic                   src_valid;
      logic [vml_pkg::CW-1:0] src_den;
      vml_pkg::side_type      src_side;

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_den   = in_den;
         assign src_side  = in_side;
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src_den   = den_ff[k-1];
         assign src_side  = side_ff[k-1];
      end

      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [vml_pkg::CW-1:0] src_rem;
         logic [vml_pkg::CW-1:0] src_low;
         logic [vml_pkg::CW-1:0] src_quo;
         logic [vml_pkg::CW:0]   part;
         logic                   take;
         logic [vml_pkg::CW-1:0] rem_in;

         if (k == 0) begin : g_first
            logic [2*vml_pkg::CW-1:0] num;
            assign num     = (l == 0) ? in_num_a : in_num_b;
            assign src_rem = num[2*vml_pkg::CW-1:vml_pkg::CW];
            assign src_low = num[vml_pkg::CW-1:0];
            assign src_quo = '0;
         end else begin : g_next
            assign src_rem = rem_ff[k-1][l];
            assign src_low = low_ff[k-1][l];
            assign src_quo = quo_ff[k-1][l];
         end

         assign part = {src_rem, src_low[vml_pkg::CW-1]};
         assign take = part >= {1'b0, src_den};
         always_comb begin
            if (take) begin
               rem_in = vml_pkg::CW'(part - {1'b0, src_den});
            end else begin
               rem_in = part[vml_pkg::CW-1:0];
            end
         end

         always_ff @(posedge clock) begin
            rem_ff[k][l] <= rem_in;
            low_ff[k][l] <= {src_low[vml_pkg::CW-2:0], 1'b0};
            quo_ff[k][l] <= {src_quo[vml_pkg::CW-2:0], take};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= src_valid;
         end
         den_ff[k]  <= src_den;
         side_ff[k] <= src_side;
      end
   end

   assign out_valid = valid_ff[vml_pkg::CW-1];
   assign out_quo_a = quo_ff[vml_pkg::CW-1][0];
   assign out_quo_b = quo_ff[vml_pkg::CW-1][1];
   assign out_side  = side_ff[vml_pkg::CW-1];

endmodule

@@ sv/vml_checker.sv @@
// port-level checks for the vector magnitude limiter, bound to the top level
// depends on vml_pkg and vector_magnitude_limiter
module vml_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic signed [vml_pkg::CW-1:0] req_x_in,
   input logic signed [vml_pkg::CW-1:0] req_y_in,
   input logic                          rsp_valid,
   input logic                          rsp_saturated
);

   a_never_busy : assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_request_answered : assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##(vml_pkg::LATENCY) rsp_valid)
      else $error("request without response");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, vml_pkg::LATENCY))
      else $error("response without request");

   a_zero_vector_passes : assert property (@(posedge clock) disable iff (reset)
      start && req_x_in == '0 && req_y_in == '0 |-> ##(vml_pkg::LATENCY) !rsp_saturated)
      else $error("zero vector saturated");

endmodule

bind vector_magnitude_limiter vml_checker u_vml_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_x_in      (req_x_in),
   .req_y_in      (req_y_in),
   .rsp_valid     (rsp_valid),
   .rsp_saturated (rsp_saturated)
);
